// ===== hdl/ezr_pkg.sv =====
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared constants, CORDIC tables and helpers for the Euler to matrix core.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_BITS_DEF      = 16;
  localparam int CORDIC_STAGES_DEF = 14;

  localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] TWO_PI_Q60  = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921FB54442D1847;

  // atan(2^-i) in Q60, i = 0..31
  function automatic logic signed [63:0] atan_q60(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    int sh;
    sum = '0;
    if (i == 0) return 64'sh0C90FDAA22168C23;
    for (k = 0; k < 64; k++) begin
      sh = 62 - i * (2 * k + 1);
      if (sh >= 0) begin
        term = (64'd1 << sh) / 64'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return $signed((sum + 64'd2) >>> 2);
  endfunction

  // 1/sqrt(prod(1+4^-i)) in Q30, by Newton iteration
  function automatic logic signed [63:0] gain_q30(input int stages);
    logic [63:0] g;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] t;
    int i;
    g = 64'd1 << 60;
    for (i = 0; i < stages && i < 30; i++) g = g + (g >> (2 * i));
    g = (g + (64'd1 << 29)) >> 30;
    y = 64'd644245094;
    for (i = 0; i < 60; i++) begin
      y2 = (y * y) >> 30;
      t  = (g * y2) >> 30;
      y  = (y * ((64'd3 << 30) - t)) >> 31;
    end
    return $signed(y);
  endfunction

  // Q30 product rounded half up
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

endpackage

// ===== hdl/ezr_stream_if.sv =====
// ----------------------------------------------------------------------------
// ezr_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface ezr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/euler_zyx_to_rotation_matrix_core.sv =====
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix_core
// Z-Y-X Euler angles to a 3x3 rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: fold register, CORDIC stages, stage A (sine/cosine register),
// stages B and C (products and sums) and the output register.
// Throughput: one beat per cycle; the whole pipe advances when the output
// register is empty or being taken.
// Reset clears the valid bits only; payload registers are not reset.
module euler_zyx_to_rotation_matrix_core import ezr_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int OUT_BITS      = OUT_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic clk,
  input logic rst,
  ezr_stream_if.sink   in_ch,
  ezr_stream_if.source out_ch
);

  localparam int NS  = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
  localparam int LAT = NS + 5;
  localparam int SH  = 32 - OUT_BITS;
  localparam logic signed [31:0] LIM = 32'sd1 <<< (OUT_BITS - 2);

  logic           en;
  logic [LAT-1:0] vld;

  assign en          = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_ch.valid};
  end

  logic signed [31:0] cy, sy, cp, sp, cr, sr;

  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(in_ch.data.yaw_angle), .cos_q30(cy), .sin_q30(sy));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(in_ch.data.pitch_angle), .cos_q30(cp), .sin_q30(sp));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(in_ch.data.roll_angle), .cos_q30(cr), .sin_q30(sr));

  // stage A: register sines/cosines
  logic signed [31:0] a_cy, a_sy, a_cp, a_sp, a_cr, a_sr;
  // stage B: pairwise products
  logic signed [31:0] b_cy, b_sy, b_sp, b_spsr, b_spcr, b_cycp, b_sycp;
  logic signed [31:0] b_sycr, b_sysr, b_cycr, b_cysr, b_cpsr, b_cpcr;
  // stage C: triple products and sums
  logic signed [31:0] c_e [0:8];

  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [31:0] v);
    logic signed [32:0] r;
    r = 33'(v);
    if (SH > 0) r = (r + (33'sd1 <<< (SH - 1))) >>> SH;
    if (r > 33'(LIM)) r = 33'(LIM);
    if (r < -33'(LIM)) r = -33'(LIM);
    return r[OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_cy <= cy; a_sy <= sy; a_cp <= cp; a_sp <= sp; a_cr <= cr; a_sr <= sr;

      b_cy   <= a_cy;
      b_sy   <= a_sy;
      b_sp   <= a_sp;
      b_spsr <= mul30(a_sp, a_sr);
      b_spcr <= mul30(a_sp, a_cr);
      b_cycp <= mul30(a_cy, a_cp);
      b_sycp <= mul30(a_sy, a_cp);
      b_sycr <= mul30(a_sy, a_cr);
      b_sysr <= mul30(a_sy, a_sr);
      b_cycr <= mul30(a_cy, a_cr);
      b_cysr <= mul30(a_cy, a_sr);
      b_cpsr <= mul30(a_cp, a_sr);
      b_cpcr <= mul30(a_cp, a_cr);

      c_e[0] <= b_cycp;
      c_e[1] <= mul30(b_cy, b_spsr) - b_sycr;
      c_e[2] <= mul30(b_cy, b_spcr) + b_sysr;
      c_e[3] <= b_sycp;
      c_e[4] <= mul30(b_sy, b_spsr) + b_cycr;
      c_e[5] <= mul30(b_sy, b_spcr) - b_cysr;
      c_e[6] <= -b_sp;
      c_e[7] <= b_cpsr;
      c_e[8] <= b_cpcr;

      out_ch.data.m00 <= to_out(c_e[0]);
      out_ch.data.m01 <= to_out(c_e[1]);
      out_ch.data.m02 <= to_out(c_e[2]);
      out_ch.data.m10 <= to_out(c_e[3]);
      out_ch.data.m11 <= to_out(c_e[4]);
      out_ch.data.m12 <= to_out(c_e[5]);
      out_ch.data.m20 <= to_out(c_e[6]);
      out_ch.data.m21 <= to_out(c_e[7]);
      out_ch.data.m22 <= to_out(c_e[8]);
    end
  end

endmodule

// ===== hdl/ezr_cordic.sv =====
// ----------------------------------------------------------------------------
// ezr_cordic
// Pipelined sine/cosine: range fold, then one register per CORDIC stage.
// ----------------------------------------------------------------------------
module ezr_cordic import ezr_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [31:0]           cos_q30,
  output logic signed [31:0]           sin_q30
);

  localparam int NS = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
  localparam logic signed [31:0] GAIN = 32'(gain_q30(CORDIC_STAGES));

  logic signed [63:0] z_fold;
  logic               neg_fold;

  always_comb begin
    logic signed [63:0] zr;
    zr = 64'(angle) <<< (60 - (ANGLE_BITS - 3));
    if (zr > PI_Q60) zr = zr - TWO_PI_Q60;
    else if (zr < -PI_Q60) zr = zr + TWO_PI_Q60;
    neg_fold = 1'b0;
    if (zr > HALF_PI_Q60) begin
      zr = zr - PI_Q60;
      neg_fold = 1'b1;
    end else if (zr < -HALF_PI_Q60) begin
      zr = zr + PI_Q60;
      neg_fold = 1'b1;
    end
    z_fold = zr;
  end

  logic signed [31:0] x [0:NS];
  logic signed [31:0] y [0:NS];
  logic signed [63:0] z [0:NS];
  logic               neg [0:NS];
  logic signed [31:0] xo;
  logic signed [31:0] yo;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= GAIN;
      y[0]   <= '0;
      z[0]   <= z_fold;
      neg[0] <= neg_fold;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic signed [63:0] ATAN = atan_q60(i);
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN;
        end
      end
    end
  end

  assign xo      = x[NS];
  assign yo      = y[NS];
  assign cos_q30 = neg[NS] ? -xo : xo;
  assign sin_q30 = neg[NS] ? -yo : yo;

endmodule

// ===== verif/euler_zyx_to_rotation_matrix_core_test.sv =====
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix_core_test
// Streams yaw/pitch/roll triples through the core in random bursts. The
// output side stalls on its own pattern. Every matrix that comes out is
// compared, element by element, against a fixed-point CORDIC model of the
// Z-Y-X rotation.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } matrix_t;

  localparam int    STAGES    = 14;
  localparam int    LIMIT     = 400000;
  localparam longint PI_Z     = 64'sh3243F6A8885A308D;
  localparam longint TWO_PI_Z = 64'sh6487ED5110B4611A;
  localparam longint HALF_PI_Z = 64'sh1921FB54442D1847;

  class rotation_scoreboard;
    longint  atan_tab[32];
    longint  gain;
    matrix_t pending[$];
    int      errors;

    function new();
      longint unsigned g, y, y2, t, term;
      longint sum;
      int sh;
      errors = 0;
      atan_tab[0] = 64'sh0C90FDAA22168C23;
      for (int i = 1; i < 32; i++) begin
        sum = 0;
        for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
          sh = 62 - i * (2 * k + 1);
          term = (64'd1 << sh) / longint'(2 * k + 1);
          if (k % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        atan_tab[i] = (sum + 2) >>> 2;
      end
      g = 64'd1 << 60;
      for (int i = 0; i < STAGES; i++) g = g + (g >> (2 * i));
      g = (g + (64'd1 << 29)) >> 30;
      y = 64'd644245094;
      for (int i = 0; i < 60; i++) begin
        y2 = (y * y) >> 30;
        t  = (g * y2) >> 30;
        y  = (y * ((64'd3 << 30) - t)) >> 31;
      end
      gain = longint'(y);
    endfunction

    function void sin_cos(logic signed [15:0] ang, output longint c, output longint s);
      longint z, x, yv, dx, dy;
      bit flip;
      flip = 0;
      z = longint'(ang) <<< 47;
      if (z > PI_Z) z = z - TWO_PI_Z;
      else if (z < -PI_Z) z = z + TWO_PI_Z;
      // fold into the right half-plane; a half turn negates both
      if (z > HALF_PI_Z) begin
        z = z - PI_Z;
        flip = 1;
      end else if (z < -HALF_PI_Z) begin
        z = z + PI_Z;
        flip = 1;
      end
      x = gain;
      yv = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = yv >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          yv = yv + dy;
          z = z - atan_tab[i];
        end else begin
          x = x + dx;
          yv = yv - dy;
          z = z + atan_tab[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -yv : yv;
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function logic signed [15:0] to_elem(longint v);
      v = (v + (64'sd1 <<< 15)) >>> 16;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
    endfunction

    function void note_angles(angles_t a);
      longint cy, sy, cp, sp, cr, sr, spsr, spcr;
      matrix_t m;
      sin_cos(a.yaw_angle, cy, sy);
      sin_cos(a.pitch_angle, cp, sp);
      sin_cos(a.roll_angle, cr, sr);
      spsr = qmul(sp, sr);
      spcr = qmul(sp, cr);
      m.m00 = to_elem(qmul(cy, cp));
      m.m01 = to_elem(qmul(cy, spsr) - qmul(sy, cr));
      m.m02 = to_elem(qmul(cy, spcr) + qmul(sy, sr));
      m.m10 = to_elem(qmul(sy, cp));
      m.m11 = to_elem(qmul(sy, spsr) + qmul(cy, cr));
      m.m12 = to_elem(qmul(sy, spcr) - qmul(cy, sr));
      m.m20 = to_elem(-sp);
      m.m21 = to_elem(qmul(cp, sr));
      m.m22 = to_elem(qmul(cp, cr));
      pending.push_back(m);
    endfunction

    function void cmp(string nm, logic signed [15:0] e, logic signed [15:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t %s mismatch: expected %0d actual %0d", $time, nm, e, a);
      end
    endfunction

    function void check_matrix(matrix_t a);
      matrix_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: expected none actual %h", $time, a);
        return;
      end
      e = pending.pop_front();
      cmp("m00", e.m00, a.m00); cmp("m01", e.m01, a.m01); cmp("m02", e.m02, a.m02);
      cmp("m10", e.m10, a.m10); cmp("m11", e.m11, a.m11); cmp("m12", e.m12, a.m12);
      cmp("m20", e.m20, a.m20); cmp("m21", e.m21, a.m21); cmp("m22", e.m22, a.m22);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;
  rotation_scoreboard sb = new();

  ezr_stream_if #(.payload_t(angles_t)) in_ch ();
  ezr_stream_if #(.payload_t(matrix_t)) out_ch ();

  euler_zyx_to_rotation_matrix_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver: phases of always-ready, mostly-ready and mostly-stalled
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ch.ready = 1;
      1: out_ch.ready = ($urandom_range(0, 3) != 0);
      default: out_ch.ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_angles(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_matrix(out_ch.data);
    end
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one beat, followed by a random gap between bursts
  task automatic send_angles(logic signed [15:0] y, logic signed [15:0] p,
                             logic signed [15:0] r);
    in_ch.valid = 1;
    in_ch.data = '{yaw_angle: y, pitch_angle: p, roll_angle: r};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(int'($urandom_range(25700, 25770)));   // near +pi
      1: return -16'(int'($urandom_range(25700, 25770)));  // near -pi
      2: return 16'(int'($urandom_range(12840, 12900)) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] edges [11];
    in_ch.valid = 0;
    in_ch.data = '0;
    edges = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd25736, 16'sd25735, -16'sd25736,
              -16'sd25735, 16'sd12868, 16'sd12867, -16'sd12868, 16'sd1};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (edges[i]) send_angles(edges[i], edges[(i + 3) % 11], edges[(i + 7) % 11]);
    send_angles(16'sd32767, 16'sd32767, 16'sd32767);
    send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
    send_angles(16'sd0, 16'sd12868, 16'sd0);   // gimbal lock
    send_angles(16'sd0, -16'sd12868, 16'sd0);
    send_angles(-16'sd1, -16'sd1, -16'sd1);
    for (int n = 0; n < 700; n++) send_angles(rand_angle(), rand_angle(), rand_angle());
    in_ch.valid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
